>>> rtl/sil_pkg.sv
`timescale 1ns / 1ps

package sil_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgWindowBase = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWindowSize = 1'b1;

  localparam int unsigned SizeW = 17;
  localparam logic [SizeW-1:0] SizeReset = 17'h10000;

  // ASCII characters the record parser looks for
  localparam logic [7:0] CharS       = 8'h53;
  localparam logic [7:0] CharThree   = 8'h33;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] CharLoA     = 8'h61;
  localparam logic [7:0] CharLoF     = 8'h66;
  localparam logic [7:0] HexTen      = 8'd10;

  // Byte count covers four address bytes and the checksum byte
  localparam logic [7:0] HeaderBytes = 8'd5;
  localparam logic [3:0] CountDigits = 4'd2;
  localparam logic [3:0] AddrDigits  = 4'd8;

  // Value type codes
  localparam logic [3:0] TypeS8   = 4'd0;
  localparam logic [3:0] TypeU8   = 4'd1;
  localparam logic [3:0] TypeS16  = 4'd2;
  localparam logic [3:0] TypeU16  = 4'd3;
  localparam logic [3:0] TypeS32  = 4'd4;
  localparam logic [3:0] TypeU32  = 4'd5;
  localparam logic [3:0] TypeF32  = 4'd6;
  localparam logic [3:0] TypeF64  = 4'd7;
  localparam logic [3:0] TypeS64  = 4'd8;
  localparam logic [3:0] TypeU64  = 4'd9;

  // Value kind codes
  localparam logic [1:0] KindSigned   = 2'd0;
  localparam logic [1:0] KindUnsigned = 2'd1;
  localparam logic [1:0] KindFloat    = 2'd2;

  typedef struct packed {
    logic load;
    logic char_step;
    logic check;
    logic fetch;
    logic publish;
    logic clear;
  } sil_cmd_t;

  typedef struct packed {
    logic read_ok;
    logic fetch_last;
    logic clear_last;
  } sil_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r = '0;
    if (c >= CharZero && c <= CharNine) begin
      r.valid = 1'b1;
      r.value = 4'(c - CharZero);
    end else if (c >= CharUpA && c <= CharUpF) begin
      r.valid = 1'b1;
      r.value = 4'(c - CharUpA + HexTen);
    end else if (c >= CharLoA && c <= CharLoF) begin
      r.valid = 1'b1;
      r.value = 4'(c - CharLoA + HexTen);
    end
    return r;
  endfunction

  // Number of bytes for a value type, zero for an invalid type
  function automatic logic [3:0] type_len(input logic [3:0] t);
    logic [3:0] n;
    case (t)
      TypeS8, TypeU8:                    n = 4'd1;
      TypeS16, TypeU16:                  n = 4'd2;
      TypeS32, TypeU32, TypeF32:         n = 4'd4;
      TypeF64, TypeS64, TypeU64:         n = 4'd8;
      default:                           n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] type_kind(input logic [3:0] t);
    logic [1:0] k;
    case (t)
      TypeU8, TypeU16, TypeU32, TypeU64: k = KindUnsigned;
      TypeF32, TypeF64:                  k = KindFloat;
      default:                           k = KindSigned;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/sil_ram.sv
`timescale 1ns / 1ps

module sil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sil_parser.sv
`timescale 1ns / 1ps

module sil_parser
  import sil_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    char_i,
  input  logic [31:0]   window_base_i,
  input  logic [32:0]   in_use_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o
);

  typedef enum logic [2:0] {
    PhStart,
    PhGotS,
    PhCount,
    PhAddr,
    PhData,
    PhSkip
  } parse_phase_e;

  parse_phase_e phase_q, phase_d;
  logic [3:0]   dcount_q, dcount_d;
  logic [7:0]   hold_q, hold_d;
  logic [7:0]   left_q, left_d;
  logic [31:0]  rec_q, rec_d;

  hex_digit_t   dig;
  logic         nl;
  logic [7:0]   hold_shift;
  logic [3:0]   dcount_inc;
  logic [32:0]  off33;
  logic         in_window;

  assign dig        = hex_decode(char_i);
  assign nl         = (char_i == CharNewline);
  assign hold_shift = {hold_q[3:0], dig.value};
  assign dcount_inc = dcount_q + 4'd1;
  assign off33      = {1'b0, rec_q} - {1'b0, window_base_i};
  assign in_window  = !off33[32] && (off33 < in_use_i);

  always_comb begin
    phase_d   = phase_q;
    dcount_d  = dcount_q;
    hold_d    = hold_q;
    left_d    = left_q;
    rec_d     = rec_q;
    wr_en_o   = 1'b0;
    wr_data_o = hold_q;
    if (step_i) begin
      case (phase_q)
        PhStart: begin
          if (!nl) phase_d = (char_i == CharS) ? PhGotS : PhSkip;
        end
        PhGotS: begin
          if (nl) begin
            phase_d = PhStart;
          end else if (char_i == CharThree) begin
            phase_d  = PhCount;
            dcount_d = '0;
            hold_d   = '0;
          end else begin
            phase_d = PhSkip;
          end
        end
        PhCount: begin
          if (nl) begin
            phase_d = PhStart;
          end else if (!dig.valid) begin
            phase_d = PhSkip;
          end else begin
            hold_d = hold_shift;
            if (dcount_inc >= CountDigits) begin
              left_d   = (hold_shift >= HeaderBytes) ? hold_shift - HeaderBytes : '0;
              rec_d    = '0;
              dcount_d = '0;
              phase_d  = PhAddr;
            end else begin
              dcount_d = dcount_inc;
            end
          end
        end
        PhAddr: begin
          if (nl) begin
            phase_d = PhStart;
          end else if (!dig.valid) begin
            phase_d = PhSkip;
          end else begin
            rec_d = {rec_q[27:0], dig.value};
            if (dcount_inc >= AddrDigits) begin
              dcount_d = '0;
              hold_d   = '0;
              phase_d  = (left_q != 8'd0) ? PhData : PhSkip;
            end else begin
              dcount_d = dcount_inc;
            end
          end
        end
        PhData: begin
          if (dcount_q == 4'd0) begin
            if (nl) begin
              phase_d = PhStart;
            end else if (dig.valid) begin
              hold_d   = {4'd0, dig.value};
              dcount_d = 4'd1;
            end else begin
              // non-hex first digit: byte reads as zero
              hold_d   = '0;
              dcount_d = 4'd2;
            end
          end else begin
            // second digit completes the pair, hex or not
            wr_data_o = (dcount_q == 4'd1 && dig.valid) ? hold_shift : hold_q;
            wr_en_o   = in_window;
            dcount_d  = '0;
            hold_d    = '0;
            rec_d     = rec_q + 32'd1;
            left_d    = left_q - 8'd1;
            if (left_q == 8'd1) phase_d = PhSkip;
            if (nl) phase_d = PhStart;
          end
        end
        default: begin
          if (nl) phase_d = PhStart;
        end
      endcase
    end
  end

  assign wr_addr_o = off33[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      dcount_q <= '0;
      hold_q   <= '0;
      left_q   <= '0;
      rec_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      dcount_q <= dcount_d;
      hold_q   <= hold_d;
      left_q   <= left_d;
      rec_q    <= rec_d;
    end
  end

endmodule

>>> rtl/sil_datapath.sv
`timescale 1ns / 1ps

module sil_datapath
  import sil_pkg::*;
#(
  parameter int unsigned IMAGE_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sil_cmd_t            cmd_i,
  output sil_status_t         status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [7:0]          text_char_i,
  input  logic [31:0]         read_address_i,
  input  logic [3:0]          value_type_i,
  input  logic [31:0]         read_flags_i,
  output logic                res_status_o,
  output logic [1:0]          value_kind_o,
  output logic [63:0]         value_bits_o,
  output logic [31:0]         address_echo_o,
  output logic [31:0]         flags_echo_o,
  output logic [3:0]          type_echo_o
);

  localparam int unsigned AW = $clog2(IMAGE_BYTES);
  localparam logic [32:0] ImageBytesW = 33'(IMAGE_BYTES);
  localparam logic [AW-1:0] LastEntry = AW'(IMAGE_BYTES - 1);

  // Window registers
  logic [31:0]      win_base_q;
  logic [SizeW-1:0] win_size_q;
  logic [32:0]      size33;
  logic [32:0]      in_use;

  // Request registers
  logic [7:0]       char_q;
  logic [31:0]      addr_q;
  logic [3:0]       type_q;
  logic [31:0]      flags_q;

  // Read sequencing
  logic [3:0]       rd_len;
  logic [1:0]       rd_kind;
  logic [32:0]      rd_off33;
  logic [32:0]      rd_end33;
  logic             read_ok;
  logic [AW-1:0]    off_q;
  logic             ok_q;
  logic [2:0]       idx_q;
  logic             rd_pend_q;
  logic [2:0]       slot_q;
  logic [7:0][7:0]  bytes_q;

  // Clearing pass
  logic [AW-1:0]    clr_q;

  // Store port
  logic             pw_en;
  logic [AW-1:0]    pw_addr;
  logic [7:0]       pw_data;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Result
  logic [63:0]      raw;
  logic             sign;
  logic [63:0]      keep;
  logic [63:0]      ext;
  logic             res_status_q;
  logic [1:0]       res_kind_q;
  logic [63:0]      res_bits_q;

  assign size33 = 33'(win_size_q);
  assign in_use = (size33 > ImageBytesW) ? ImageBytesW : size33;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_base_q <= '0;
      win_size_q <= SizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWindowBase: win_base_q <= cfg_data_i;
        CfgWindowSize: win_size_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q  <= text_char_i;
      addr_q  <= read_address_i;
      type_q  <= value_type_i;
      flags_q <= read_flags_i;
    end
  end

  sil_parser #(
    .AW (AW)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (cmd_i.char_step),
    .char_i        (char_q),
    .window_base_i (win_base_q),
    .in_use_i      (in_use),
    .wr_en_o       (pw_en),
    .wr_addr_o     (pw_addr),
    .wr_data_o     (pw_data)
  );

  // Bounds check of a typed read
  assign rd_len   = type_len(type_q);
  assign rd_kind  = type_kind(type_q);
  assign rd_off33 = {1'b0, addr_q} - {1'b0, win_base_q};
  assign rd_end33 = rd_off33 + 33'(rd_len);
  assign read_ok  = (rd_len != 4'd0) && !rd_off33[32] && (rd_end33 <= in_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      rd_pend_q <= cmd_i.fetch;
      if (cmd_i.check) begin
        idx_q <= '0;
      end else if (cmd_i.fetch) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      off_q   <= rd_off33[AW-1:0];
      ok_q    <= read_ok;
      bytes_q <= '0;
    end else if (rd_pend_q) begin
      bytes_q[slot_q] <= ram_rdata;
    end
    if (cmd_i.fetch) slot_q <= idx_q;
  end

  always_comb begin
    ram_we    = cmd_i.clear || pw_en;
    ram_wdata = cmd_i.clear ? 8'd0 : pw_data;
    if (cmd_i.clear) begin
      ram_addr = clr_q;
    end else if (pw_en) begin
      ram_addr = pw_addr;
    end else begin
      ram_addr = off_q + AW'(idx_q);
    end
  end

  sil_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sign extension of short signed values
  assign raw = bytes_q;
  always_comb begin
    case (rd_len)
      4'd1: begin
        sign = raw[7];
        keep = 64'h0000_0000_0000_00FF;
      end
      4'd2: begin
        sign = raw[15];
        keep = 64'h0000_0000_0000_FFFF;
      end
      4'd4: begin
        sign = raw[31];
        keep = 64'h0000_0000_FFFF_FFFF;
      end
      default: begin
        sign = 1'b0;
        keep = '1;
      end
    endcase
    ext = (rd_kind == KindSigned && sign) ? (raw | ~keep) : raw;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      res_status_q <= !ok_q;
      res_kind_q   <= ok_q ? rd_kind : KindSigned;
      res_bits_q   <= ok_q ? ext : '0;
    end
  end

  assign status_o.read_ok    = read_ok;
  assign status_o.fetch_last = (idx_q == 3'(rd_len - 4'd1));
  assign status_o.clear_last = (clr_q == LastEntry);

  assign res_status_o   = res_status_q;
  assign value_kind_o   = res_kind_q;
  assign value_bits_o   = res_bits_q;
  assign address_echo_o = addr_q;
  assign flags_echo_o   = flags_q;
  assign type_echo_o    = type_q;

endmodule

>>> rtl/sil_ctrl.sv
`timescale 1ns / 1ps

module sil_ctrl
  import sil_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_read_i,
  input  sil_status_t status_i,
  output sil_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StChar,
    StCheck,
    StFetch,
    StDrain,
    StFinish
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        busy_q;
  logic        done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = StIdle;
      end
      StIdle: begin
        if (start_i && !busy_q) begin
          cmd_o.load = 1'b1;
          state_d    = is_read_i ? StCheck : StChar;
        end
      end
      StChar: begin
        cmd_o.char_step = 1'b1;
        state_d         = StIdle;
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.read_ok ? StFetch : StFinish;
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        if (status_i.fetch_last) state_d = StDrain;
      end
      StDrain: begin
        // last byte arrives from the store
        state_d = StFinish;
      end
      StFinish: begin
        cmd_o.publish = 1'b1;
        state_d       = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != StIdle);
      done_q  <= (state_q == StFinish);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> rtl/srecord_image_loader_reader_top.sv
// S3 record image loader with typed reads.
//
// Commands enter on start_i while busy_o is low. cmd_i = 0 feeds one
// character of S-record text (text_char_i); S3 data bytes that fall in
// the window [window_base, window_base + min(window_size, IMAGE_BYTES))
// land in a byte store. cmd_i = 1 is a typed read of 1, 2, 4 or 8
// little-endian bytes at read_address_i; the result shows on the result
// ports with done_o high for one cycle, together with the echoed request.
// A text character occupies the block through its character step. A read
// occupies it through the check, one fetch per byte, a drain and the publish,
// one store byte per cycle through the single store port; a read that
// fails its bounds or type check goes from the check to the publish.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready;
// write it only while the block is idle.
// After reset the store is swept to zero one byte per cycle, so busy_o
// stays high, and no command is taken, until the whole store is clear.
// The receiver cannot stall: done_o is a one-cycle strobe.
`timescale 1ns / 1ps

module srecord_image_loader_reader_top
  import sil_pkg::*;
#(
  parameter int unsigned IMAGE_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cmd_i,
  input  logic [7:0]         text_char_i,
  input  logic [31:0]        read_address_i,
  input  logic [3:0]         value_type_i,
  input  logic [31:0]        read_flags_i,
  output logic               done_o,
  output logic               status_o,
  output logic [1:0]         value_kind_o,
  output logic [63:0]        value_bits_o,
  output logic [31:0]        address_echo_o,
  output logic [31:0]        flags_echo_o,
  output logic [3:0]         type_echo_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  sil_cmd_t    cmd;
  sil_status_t status;

  assign cfg_ready_o = 1'b1;

  sil_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .is_read_i (cmd_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  sil_datapath #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .text_char_i    (text_char_i),
    .read_address_i (read_address_i),
    .value_type_i   (value_type_i),
    .read_flags_i   (read_flags_i),
    .res_status_o   (status_o),
    .value_kind_o   (value_kind_o),
    .value_bits_o   (value_bits_o),
    .address_echo_o (address_echo_o),
    .flags_echo_o   (flags_echo_o),
    .type_echo_o    (type_echo_o)
  );

  // A text character never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cmd_i) |=> !done_o ##1 !done_o)
    else $error("result strobe after a text character");

  // A result only shows once the block is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A failed read returns a zero signed value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (value_bits_o == 64'd0 && value_kind_o == KindSigned))
    else $error("failed read with nonzero value");

  // A read keeps the block busy until its result is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i) |=> busy_o && !done_o)
    else $error("read transfer did not occupy the block");

endmodule

>>> verif/srecord_image_loader_reader_top_tb.sv
`timescale 1ns / 1ps

module srecord_image_loader_reader_top_tb;
  import sil_pkg::*;

  localparam int unsigned StoreBytes    = 65536;
  localparam int unsigned IdlePct       = 29;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 340;
  localparam int unsigned CycleLimit    = 1000000;

  localparam logic CmdText = 1'b0;
  localparam logic CmdRead = 1'b1;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  // Any code from 10 up is rejected by the block
  localparam logic [3:0] TypeNone = 4'd12;

  typedef enum logic [2:0] {
    LineWait, LineGotS, LineCount, LineAddr, LineData, LineSkip
  } line_phase_e;

  typedef struct packed {
    logic        status;
    logic [1:0]  kind;
    logic [63:0] value;
    logic [31:0] addr;
    logic [31:0] flags;
    logic [3:0]  vtype;
  } read_result_t;

  class image_scoreboard;
    logic [7:0]   image_mem [StoreBytes];
    line_phase_e  line_phase;
    logic [3:0]   digits;
    logic [7:0]   hold;
    logic [7:0]   remaining;
    logic [31:0]  rec_addr;
    logic [31:0]  win_base;
    logic [16:0]  win_size;
    read_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      foreach (image_mem[i]) image_mem[i] = 8'h00;
      line_phase = LineWait;
      digits     = 4'd0;
      hold       = 8'h00;
      remaining  = 8'h00;
      rec_addr   = 32'h0;
      win_base   = 32'h0;
      win_size   = SizeReset;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx == CfgWindowBase) win_base = data;
      else win_size = data[SizeW-1:0];
    endfunction

    function longint unsigned bytes_in_use();
      return (win_size > StoreBytes) ? StoreBytes : longint'(win_size);
    endfunction

    // '0'..'9' carry the digit in the low nibble; letters of either case
    // carry digit - 9
    function bit hex_digit(logic [7:0] c, output logic [3:0] n);
      n = 4'd0;
      if (c >= CharZero && c <= CharNine) n = c[3:0];
      else if ((c >= CharUpA && c <= CharUpF) || (c >= CharLoA && c <= CharLoF))
        n = c[3:0] + 4'd9;
      else return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned bytes_of(logic [3:0] t);
      case (t)
        TypeS8, TypeU8:            return 1;
        TypeS16, TypeU16:          return 2;
        TypeS32, TypeU32, TypeF32: return 4;
        TypeF64, TypeS64, TypeU64: return 8;
        default:                   return 0;
      endcase
    endfunction

    function logic [1:0] kind_of(logic [3:0] t);
      case (t)
        TypeU8, TypeU16, TypeU32, TypeU64: return KindUnsigned;
        TypeF32, TypeF64:                  return KindFloat;
        default:                           return KindSigned;
      endcase
    endfunction

    function void take_char(logic [7:0] c);
      logic             is_hex;
      logic             nl;
      logic [3:0]       nib;
      logic [7:0]       data_byte;
      longint unsigned  off;
      is_hex = hex_digit(c, nib);
      nl = (c == CharNewline);
      case (line_phase)
        LineWait: begin
          if (!nl) line_phase = (c == CharS) ? LineGotS : LineSkip;
        end
        LineGotS: begin
          if (nl) line_phase = LineWait;
          else if (c == CharThree) begin
            line_phase = LineCount;
            digits = 4'd0;
            hold = 8'h00;
          end else line_phase = LineSkip;
        end
        LineCount: begin
          if (nl) line_phase = LineWait;
          else if (!is_hex) line_phase = LineSkip;
          else begin
            hold = {hold[3:0], nib};
            digits = digits + 4'd1;
            if (digits >= CountDigits) begin
              remaining = (hold >= HeaderBytes) ? hold - HeaderBytes : 8'h00;
              rec_addr = 32'h0;
              digits = 4'd0;
              line_phase = LineAddr;
            end
          end
        end
        LineAddr: begin
          if (nl) line_phase = LineWait;
          else if (!is_hex) line_phase = LineSkip;
          else begin
            rec_addr = {rec_addr[27:0], nib};
            digits = digits + 4'd1;
            if (digits >= AddrDigits) begin
              digits = 4'd0;
              hold = 8'h00;
              line_phase = (remaining != 0) ? LineData : LineSkip;
            end
          end
        end
        LineData: begin
          if (digits == 4'd0) begin
            if (nl) line_phase = LineWait;
            else if (is_hex) begin
              hold = {4'h0, nib};
              digits = 4'd1;
            end else begin
              // bad first digit: the pair yields zero
              hold = 8'h00;
              digits = 4'd2;
            end
          end else begin
            data_byte = hold;
            if (digits == 4'd1 && is_hex) data_byte = {hold[3:0], nib};
            digits = 4'd0;
            hold = 8'h00;
            if (rec_addr >= win_base) begin
              off = 64'(rec_addr - win_base);
              if (off < bytes_in_use()) image_mem[off] = data_byte;
            end
            rec_addr = rec_addr + 32'd1;
            remaining = remaining - 8'd1;
            if (remaining == 0) line_phase = LineSkip;
            if (nl) line_phase = LineWait;
          end
        end
        default: begin
          if (nl) line_phase = LineWait;
        end
      endcase
    endfunction

    function void note_item(logic cmd, logic [7:0] c, logic [31:0] addr,
                            logic [3:0] vt, logic [31:0] flags);
      read_result_t    r;
      int unsigned     len;
      int unsigned     i;
      longint unsigned off;
      if (cmd == CmdText) begin
        take_char(c);
        return;
      end
      len = bytes_of(vt);
      r.status = StatusFail;
      r.kind   = KindSigned;
      r.value  = 64'h0;
      r.addr   = addr;
      r.flags  = flags;
      r.vtype  = vt;
      if (len != 0 && addr >= win_base) begin
        off = 64'(addr - win_base);
        if (off + len <= bytes_in_use()) begin
          for (i = len; i > 0; i--) r.value = {r.value[55:0], image_mem[off + i - 1]};
          r.kind = kind_of(vt);
          if (r.kind == KindSigned) begin
            case (len)
              1: r.value = {{56{r.value[7]}}, r.value[7:0]};
              2: r.value = {{48{r.value[15]}}, r.value[15:0]};
              4: r.value = {{32{r.value[31]}}, r.value[31:0]};
              default: ;
            endcase
          end
          r.status = StatusOk;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(read_result_t got);
      read_result_t want;
      if (expected_q.size() == 0) begin
        $error("read result at address %0h arrived with no request waiting", got.addr);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("status", 64'(want.status), 64'(got.status));
      compare("value_kind", 64'(want.kind), 64'(got.kind));
      compare("value_bits", want.value, got.value);
      compare("address_echo", 64'(want.addr), 64'(got.addr));
      compare("flags_echo", 64'(want.flags), 64'(got.flags));
      compare("type_echo", 64'(want.vtype), 64'(got.vtype));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               cmd_i;
  logic [7:0]         text_char_i;
  logic [31:0]        read_address_i;
  logic [3:0]         value_type_i;
  logic [31:0]        read_flags_i;
  logic               done_o;
  logic               status_o;
  logic [1:0]         value_kind_o;
  logic [63:0]        value_bits_o;
  logic [31:0]        address_echo_o;
  logic [31:0]        flags_echo_o;
  logic [3:0]         type_echo_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  srecord_image_loader_reader_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .text_char_i   (text_char_i),
    .read_address_i(read_address_i),
    .value_type_i  (value_type_i),
    .read_flags_i  (read_flags_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .value_kind_o  (value_kind_o),
    .value_bits_o  (value_bits_o),
    .address_echo_o(address_echo_o),
    .flags_echo_o  (flags_echo_o),
    .type_echo_o   (type_echo_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  image_scoreboard board;
  logic [31:0]     cur_base;
  logic [16:0]     cur_size;
  bit              no_idle;
  int unsigned     counted;
  int unsigned     text_sent;
  int unsigned     lines_sent;
  int unsigned     reads_sent;
  int unsigned     cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      board.check_result(read_result_t'({status_o, value_kind_o, value_bits_o,
                                         address_echo_o, flags_echo_o, type_echo_o}));
  end

  // Hold start high until the transfer; idle first at random unless no_idle
  task automatic send_item(logic cmd, logic [7:0] c, logic [31:0] addr,
                           logic [3:0] vt, logic [31:0] flags);
    if (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    text_char_i    <= c;
    read_address_i <= addr;
    value_type_i   <= vt;
    read_flags_i   <= flags;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_item(cmd, c, addr, vt, flags);
    if (cmd == CmdText) text_sent++;
    else reads_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(CmdText, c, $urandom(), 4'($urandom_range(0, 15)), $urandom());
  endtask

  // Drain, settle, then write both window registers while idle
  task automatic set_window(logic [31:0] base, logic [16:0] size);
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgWindowBase;
    cfg_data_i  <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(CfgWindowBase, base);
    cfg_index_i <= CfgWindowSize;
    cfg_data_i  <= {15'h0, size};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(CfgWindowSize, {15'h0, size});
    cfg_valid_i <= 1'b0;
    cur_base = base;
    cur_size = size;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CharZero + 8'(n);
    return ($urandom_range(0, 1) ? CharUpA : CharLoA) + 8'(n) - HexTen;
  endfunction

  // Mostly inside the window near its base, some at its top edge, some anywhere
  function automatic logic [31:0] pick_address();
    int unsigned span;
    span = (cur_size < 256) ? cur_size : 256;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1, 2:    return cur_base + 32'(cur_size) - $urandom_range(0, 12);
      default: return cur_base + $urandom_range(0, span + 8) - 32'd8;
    endcase
  endfunction

  task automatic send_record_line();
    logic [7:0]  line_q[$];
    logic [7:0]  count;
    logic [7:0]  data_byte;
    logic [31:0] addr;
    int          i;
    case ($urandom_range(0, 9))
      0:       count = 8'($urandom_range(0, 4));
      1:       count = 8'($urandom_range(21, 40));
      default: count = 8'($urandom_range(5, 20));
    endcase
    addr = pick_address();
    line_q.push_back(CharS);
    line_q.push_back(CharThree);
    line_q.push_back(hex_char(count[7:4]));
    line_q.push_back(hex_char(count[3:0]));
    for (i = 7; i >= 0; i--) line_q.push_back(hex_char(addr[4*i +: 4]));
    // data pairs, then the checksum pair
    for (i = 4; i < int'(count); i++) begin
      data_byte = 8'($urandom());
      line_q.push_back(hex_char(data_byte[7:4]));
      line_q.push_back(hex_char(data_byte[3:0]));
    end
    case ($urandom_range(0, 14))
      0: line_q[$urandom_range(2, 11)] = $urandom_range(0, 1) ? "G" : 8'($urandom());
      1: line_q[$urandom_range(1, line_q.size() - 1)] = CharNewline;
      2: line_q[$urandom_range(12, line_q.size() - 1)] = 8'($urandom());
      3: line_q[1] = $urandom_range(0, 1) ? "1" : 8'($urandom());
      default: ;
    endcase
    line_q.push_back(CharNewline);
    foreach (line_q[j]) send_char(line_q[j]);
    counted += line_q.size();
    lines_sent++;
  endtask

  task automatic send_reads();
    logic [3:0] vt;
    repeat ($urandom_range(1, 3)) begin
      vt = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 9))
                                         : 4'($urandom_range(10, 15));
      send_item(CmdRead, 8'($urandom()), pick_address(), vt, $urandom());
      counted++;
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 2) == 0) begin
      send_char(CharS);
      send_char(8'($urandom()));
    end else begin
      repeat ($urandom_range(1, 5)) send_char(8'($urandom()));
    end
    if ($urandom_range(0, 1)) send_char(CharNewline);
  endtask

  initial begin
    string       directed_line;
    logic [31:0] phase_base [NumPhases];
    logic [16:0] phase_size [NumPhases];
    int unsigned phase_start;
    int unsigned pick;
    board = new();
    counted = 0;
    text_sent = 0;
    lines_sent = 0;
    reads_sent = 0;
    no_idle = 1'b0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    cmd_i          <= CmdText;
    text_char_i    <= 8'h00;
    read_address_i <= 32'h0;
    value_type_i   <= TypeS8;
    read_flags_i   <= 32'h0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CfgWindowBase;
    cfg_data_i     <= 32'h0;

    phase_base[0] = 32'h0;          phase_size[0] = SizeReset;
    phase_base[1] = 32'h1000_0000;  phase_size[1] = 17'd256;
    phase_base[2] = 32'hFFFF_0000;  phase_size[2] = SizeReset;
    phase_base[3] = $urandom();     phase_size[3] = 17'd0;
    phase_base[4] = 32'hFFFF_FFF0;  phase_size[4] = 17'd16;
    phase_base[5] = $urandom();     phase_size[5] = 17'($urandom_range(1, StoreBytes));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: mixed-case pair, bad first digit, newline closing a pair whose
    // byte lands just past the window, then reads of every width and failures
    set_window(32'h0, SizeReset);
    directed_line = "S3080000FFFEFfG87\n";
    for (int k = 0; k < directed_line.len(); k++) send_char(directed_line[k]);
    send_item(CmdRead, 8'h00, 32'h0000_FFFE, TypeS16, 32'h0);
    send_item(CmdRead, 8'hFF, 32'h0000_FFFE, TypeS8, 32'hFFFF_FFFF);
    send_item(CmdRead, 8'h00, 32'h0000_FFF8, TypeU64, 32'h1234_5678);
    send_item(CmdRead, 8'h00, 32'h0000_FFFC, TypeF32, 32'h0);
    send_item(CmdRead, 8'h00, 32'h0000_FFFF, TypeU16, 32'h0);
    send_item(CmdRead, 8'h00, 32'h0, TypeNone, 32'h0);
    send_item(CmdRead, 8'h00, 32'hFFFF_FFFF, TypeU8, 32'hFFFF_FFFF);

    for (int p = 0; p < NumPhases; p++) begin
      set_window(phase_base[p], phase_size[p]);
      no_idle = (p == 1);
      phase_start = counted;
      while (counted - phase_start < ItemsPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) send_record_line();
        else if (pick < 88) send_reads();
        else send_noise();
      end
    end

    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d read results never arrived", board.pending());
      board.errors++;
    end

    $display("Covered %0d text characters (%0d S3 lines, some broken) and %0d typed reads",
             text_sent, lines_sent, reads_sent);
    $display("over %0d window settings, empty and top-of-address-space windows included",
             NumPhases + 1);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sil_pkg.sv
rtl/sil_ram.sv
rtl/sil_parser.sv
rtl/sil_datapath.sv
rtl/sil_ctrl.sv
rtl/srecord_image_loader_reader_top.sv
verif/srecord_image_loader_reader_top_tb.sv
